>>> rtl/core/hsvh_pkg.sv
// Shared types, constants and binning functions for the HSV channel histogram.
// Used by every module of the block; depends on nothing.
`default_nettype none

package hsvh_pkg;

   // Field widths.
   localparam int PIX_W    = 8;
   localparam int BIN_W    = 4;
   localparam int COUNT_W  = 21;
   localparam int SUM_W    = 28;
   localparam int SEL_W    = 2;

   // Bin counts per channel.
   localparam int NUM_BINS = 10;
   localparam int HUE_BINS = 8;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 4;

   // Saturation and value bin edges.
   localparam logic [PIX_W-1:0] SV_LOW  = 8'd40;
   localparam logic [PIX_W-1:0] SV_HIGH = 8'd240;
   localparam int               SV_STEP = 25;

   // Hue edges; a hue above an edge other than the first moves one bin up.
   localparam logic [PIX_W-1:0] HUE_EDGES [HUE_BINS] =
      '{8'd0, 8'd10, 8'd25, 8'd34, 8'd77, 8'd99, 8'd124, 8'd155};

   // Channel select codes (the unused code behaves as value).
   localparam logic [SEL_W-1:0] CH_HUE = 2'd0;
   localparam logic [SEL_W-1:0] CH_SAT = 2'd1;
   localparam logic [SEL_W-1:0] CH_VAL = 2'd2;
   localparam logic [SEL_W-1:0] CH_RESET = CH_SAT;

   // Result kinds.
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_TOTAL = 1'b1;

   // One classified pixel waiting for the back part.
   typedef struct packed {
      logic [BIN_W-1:0] bin;
      logic [PIX_W-1:0] chan;
      logic             last;
      logic             hue_mode;
   } queue_entry_type;

   // Back part sequencer states.
   typedef enum logic {
      ST_PIXEL,
      ST_DUMP
   } back_state_type;

   // Hue bin: count the edges after the first that the hue lies above.
   function automatic logic [BIN_W-1:0] hue_bin(input logic [PIX_W-1:0] h);
      logic [BIN_W-1:0] b;
      b = '0;
      for (int k = 1; k < HUE_BINS; k++) begin
         if (h > HUE_EDGES[k]) begin
            b = b + BIN_W'(1);
         end
      end
      return b;
   endfunction

   // Saturation/value bin: end bins by compare, inner bins from 41, then 25 wide from 65.
   function automatic logic [BIN_W-1:0] sv_bin(input logic [PIX_W-1:0] s);
      logic [BIN_W-1:0] b;
      b = BIN_W'(1);
      for (int k = 1; k < NUM_BINS - 2; k++) begin
         if (s >= PIX_W'(SV_LOW + SV_STEP * k)) begin
            b = b + BIN_W'(1);
         end
      end
      if (s <= SV_LOW) begin
         b = '0;
      end else if (s >= SV_HIGH) begin
         b = BIN_W'(NUM_BINS - 1);
      end
      return b;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/hsvh_front.sv
// Front part: holds the channel select register, accepts pixels and bins them.
// Depends on hsvh_pkg; feeds hsvh_queue.
`default_nettype none

module hsvh_front
   import hsvh_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [SEL_W-1:0]       csr_wdata,
   input  wire logic                   req_tvalid,
   input  wire logic [3*PIX_W-1:0]     req_tdata,
   input  wire logic                   req_tlast,
   input  wire logic                   q_full,
   output logic                        push,
   output queue_entry_type             push_entry
);

   logic [SEL_W-1:0] sel_ff;
   logic [PIX_W-1:0] hue, sat, val;

   // Channel select register.
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= CH_RESET;
      end else if (csr_we) begin
         sel_ff <= csr_wdata;
      end
   end

   assign hue = req_tdata[PIX_W-1:0];
   assign sat = req_tdata[2*PIX_W-1:PIX_W];
   assign val = req_tdata[3*PIX_W-1:2*PIX_W];

   // An item is taken whenever the queue has room.
   assign push = req_tvalid && !q_full;

   // Pick the channel and its bin.
   always_comb begin
      push_entry.last     = req_tlast;
      push_entry.hue_mode = (sel_ff == CH_HUE);
      case (sel_ff)
         CH_HUE: begin
            push_entry.chan = hue;
            push_entry.bin  = hue_bin(hue);
         end
         CH_SAT: begin
            push_entry.chan = sat;
            push_entry.bin  = sv_bin(sat);
         end
         default: begin
            push_entry.chan = val;
            push_entry.bin  = sv_bin(val);
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/hsvh_queue.sv
// Short queue of classified pixels between the front and the back part.
// Depends on hsvh_pkg.
`default_nettype none

module hsvh_queue
   import hsvh_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire queue_entry_type  push_entry,
   input  wire logic             pop,
   output logic                  full,
   output logic                  not_empty,
   output queue_entry_type       head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type  mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem[rd_ptr_ff];

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/hsvh_back.sv
// Back part: accumulates bin counts and sums, emits pixel results and frame dumps.
// Depends on hsvh_pkg; takes items from hsvh_queue.
`default_nettype none

module hsvh_back
   import hsvh_pkg::*;
#(
   parameter int MAX_PIXELS = 1048576
)
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_not_empty,
   input  wire queue_entry_type              q_head,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [BIN_W+COUNT_W+SUM_W+2:0]    rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int DATA_W = BIN_W + COUNT_W + SUM_W + 3;
   localparam longint unsigned COUNT_MAX = (longint'(1) << COUNT_W) - 1;
   localparam longint unsigned SUM_MAX   = (longint'(1) << SUM_W) - 1;
   localparam longint unsigned COUNT_CAP = (longint'(MAX_PIXELS) > COUNT_MAX) ?
                                           COUNT_MAX : longint'(MAX_PIXELS);
   localparam longint unsigned SUM_RAW   = longint'(MAX_PIXELS) * 255;
   localparam longint unsigned SUM_CAP   = (SUM_RAW > SUM_MAX) ? SUM_MAX : SUM_RAW;
   localparam logic [COUNT_W-1:0] COUNT_LIM = COUNT_CAP[COUNT_W-1:0];
   localparam logic [SUM_W-1:0]   SUM_LIM   = SUM_CAP[SUM_W-1:0];

   back_state_type     state_ff, state_in;
   logic [BIN_W-1:0]   idx_ff, idx_in;
   logic               dump_hue_ff, dump_hue_in;
   logic [COUNT_W-1:0] count_ff [NUM_BINS];
   logic [SUM_W-1:0]   sum_ff   [NUM_BINS];

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [BIN_W-1:0]   rsp_bin_ff, rsp_bin_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               advance, dump_end, upd_en, clear_all;
   logic [BIN_W-1:0]   rd_addr;
   logic [COUNT_W-1:0] rd_count, upd_count_in;
   logic [SUM_W-1:0]   rd_sum, upd_sum_in;
   logic [SUM_W:0]     sum_wide;

   // The output register can take a new result when empty or being drained.
   assign advance  = !rsp_valid_ff || rsp_tready;
   assign dump_end = (idx_ff == (dump_hue_ff ? BIN_W'(HUE_BINS - 1) : BIN_W'(NUM_BINS - 1)));

   // One read port on the bin stores, shared by updates and dumps.
   assign rd_addr  = (state_ff == ST_DUMP) ? idx_ff : q_head.bin;
   assign rd_count = count_ff[rd_addr];
   assign rd_sum   = sum_ff[rd_addr];

   // Saturating count and sum updates.
   assign sum_wide     = {1'b0, rd_sum} + (SUM_W + 1)'(q_head.chan);
   assign upd_count_in = (rd_count >= COUNT_LIM) ? COUNT_LIM : rd_count + COUNT_W'(1);
   assign upd_sum_in   = (sum_wide > {1'b0, SUM_LIM}) ? SUM_LIM : sum_wide[SUM_W-1:0];

   // Next state of the sequencer.
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      dump_hue_in = dump_hue_ff;
      unique case (state_ff)
         ST_PIXEL: begin
            if (advance && q_not_empty && q_head.last) begin
               state_in    = ST_DUMP;
               idx_in      = '0;
               dump_hue_in = q_head.hue_mode;
            end
         end
         ST_DUMP: begin
            if (advance) begin
               if (dump_end) begin
                  state_in = ST_PIXEL;
               end else begin
                  idx_in = idx_ff + BIN_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_PIXEL;
         end
      endcase
   end

   // Sequencer outputs: queue pop, store control and the next result.
   always_comb begin
      pop          = 1'b0;
      upd_en       = 1'b0;
      clear_all    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_bin_in   = rsp_bin_ff;
      rsp_count_in = rsp_count_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_PIXEL: begin
            if (advance) begin
               rsp_valid_in = q_not_empty;
               pop          = q_not_empty;
               upd_en       = q_not_empty;
               rsp_kind_in  = KIND_PIXEL;
               rsp_bin_in   = q_head.bin;
               rsp_count_in = '0;
               rsp_sum_in   = '0;
               rsp_last_in  = !q_head.last;
            end
         end
         ST_DUMP: begin
            if (advance) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_TOTAL;
               rsp_bin_in   = idx_ff;
               rsp_count_in = rd_count;
               rsp_sum_in   = rd_sum;
               rsp_last_in  = dump_end;
               clear_all    = dump_end;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Sequencer and output valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PIXEL;
         idx_ff       <= '0;
         dump_hue_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         dump_hue_ff  <= dump_hue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_bin_ff   <= rsp_bin_in;
      rsp_count_ff <= rsp_count_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Bin stores: cleared at reset and after the final total of a dump.
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            count_ff[i] <= '0;
            sum_ff[i]   <= '0;
         end
      end else if (upd_en) begin
         count_ff[q_head.bin] <= upd_count_in;
         sum_ff[q_head.bin]   <= upd_sum_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = DATA_W'({rsp_sum_ff, rsp_count_ff, rsp_bin_ff});

endmodule

`default_nettype wire

>>> rtl/core/hsv_channel_bin_histogram_top.sv
// Top level of the HSV channel histogram: front, queue and back part.
// Depends on hsvh_pkg, hsvh_front, hsvh_queue and hsvh_back.
//
// Usage:
//   req_* carries one HSV pixel per item; req_tlast marks a frame's last pixel.
//   csr_we/csr_wdata write the channel select (0 hue, 1 saturation, 2 value);
//   write it only while no item is in flight.
//   rsp_* carries results. Every pixel gives one pixel result (tuser 0) with its
//   bin. After a frame's last pixel, the per-bin totals follow (tuser 1), 8 for
//   hue and 10 otherwise, the final one with tlast set; the stores then clear.
//   An ordinary pixel result carries tlast 1, a frame's last pixel result 0.
// Flow and rate:
//   A pixel goes into the queue and its result into the output register. The back part
//   retires one result per cycle when the output does not stall, so ordinary pixels
//   stream at one per cycle; after a frame's last pixel the back part emits the totals,
//   while the 4-entry queue keeps taking pixels until it fills.
// Reset and stalls:
//   Reset empties the queue and output register, clears all bin stores and
//   sets the channel select to saturation. When rsp_tready is low the output
//   register holds, the back part waits, and req_tready drops once the queue
//   is full.
`default_nettype none

module hsv_channel_bin_histogram_top
   import hsvh_pkg::*;
#(
   parameter int MAX_PIXELS = 1048576
)
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Configuration
   input  wire logic                         csr_we,
   input  wire logic [SEL_W-1:0]             csr_wdata,
   // Pixel input
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [3*PIX_W-1:0]           req_tdata,  // hue, sat, val
   input  wire logic                         req_tlast,  // last_pixel
   // Results
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [BIN_W+COUNT_W+SUM_W+2:0]    rsp_tdata,  // bin_number, bin_count, bin_sum, pad
   output logic                              rsp_tuser,  // kind
   output logic                              rsp_tlast   // last_result
);

   logic            push, pop, q_full, q_not_empty;
   queue_entry_type push_entry, q_head;

   // Front: accept and classify.
   hsvh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   assign req_tready = !q_full;

   // Queue between front and back.
   hsvh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   // Back: accumulate and report.
   hsvh_back #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> rtl/core/hsvh_checker.sv
// Port-level checks on the HSV channel histogram, and their bind to the top level.
// Depends on hsvh_pkg and hsv_channel_bin_histogram_top.
`default_nettype none

module hsvh_checker
   import hsvh_pkg::*;
(
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_tvalid,
   input wire logic                         rsp_tready,
   input wire logic [BIN_W+COUNT_W+SUM_W+2:0] rsp_tdata,
   input wire logic                         rsp_tuser,
   input wire logic                         rsp_tlast
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // No result right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Pixel results carry no count and no sum.
   a_pixel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_PIXEL) |->
         rsp_tdata[BIN_W+COUNT_W+SUM_W-1:BIN_W] == '0)
      else $error("pixel result with nonzero totals");

   // The closing total of a dump is the top hue or saturation/value bin.
   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_TOTAL) && rsp_tlast |->
         (rsp_tdata[BIN_W-1:0] == BIN_W'(HUE_BINS - 1))
         || (rsp_tdata[BIN_W-1:0] == BIN_W'(NUM_BINS - 1)))
      else $error("dump closed on a wrong bin");

endmodule

bind hsv_channel_bin_histogram_top hsvh_checker u_hsvh_checker (.*);

`default_nettype wire
